// ----- hdl/rmsd_pkg.sv -----
// rmsd_pkg: shared codes, queue word and status types for the RGB matrix scan driver.
// No dependencies; the front, queue, back and top files refer to it by scoped names.
`timescale 1ns / 1ps

package rmsd_pkg;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_SCAN  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_SCAN,
    CMD_CLEAR
  } cmd_kind_t;

  // one word of the front-to-back queue
  typedef struct packed {
    cmd_kind_t  kind;
    logic       bottom;
    logic [7:0] row;
    logic [7:0] col;
    logic [2:0] rgb;
  } cmd_t;

  typedef struct packed {
    logic [3:0] row_address;
    logic       latch;
    logic       blank;
    logic       frame_last;
  } scan_meta_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_RUN,
    BK_CLEAR
  } back_state_t;

endpackage

// ----- hdl/rmsd_if.sv -----
// Valid/ready channel interfaces of the RGB matrix scan driver.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

interface rmsd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] pixel_row;
  logic [7:0] pixel_col;
  logic       red_in;
  logic       green_in;
  logic       blue_in;

  modport source (output valid, mode, pixel_row, pixel_col, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, mode, pixel_row, pixel_col, red_in, green_in, blue_in,
                output ready);
endinterface

interface rmsd_out_if;
  logic       valid;
  logic       ready;
  logic       top_red;
  logic       top_green;
  logic       top_blue;
  logic       bottom_red;
  logic       bottom_green;
  logic       bottom_blue;
  logic [3:0] row_address;
  logic       latch;
  logic       blank;
  logic       frame_last;

  modport source (output valid, top_red, top_green, top_blue, bottom_red, bottom_green,
                  bottom_blue, row_address, latch, blank, frame_last,
                  input ready);
  modport sink (input valid, top_red, top_green, top_blue, bottom_red, bottom_green,
                bottom_blue, row_address, latch, blank, frame_last,
                output ready);
endinterface

// ----- hdl/rmsd_front.sv -----
// rmsd_front: accepts input words, range-checks writes and classifies them into queue words.
// Depends on rmsd_pkg.
`timescale 1ns / 1ps

module rmsd_front #(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 32
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  logic [7:0]        pixel_row,
  input  logic [7:0]        pixel_col,
  input  logic              red_in,
  input  logic              green_in,
  input  logic              blue_in,
  input  logic              q_space,
  input  logic              init_busy,
  output logic              push,
  output rmsd_pkg::cmd_t    push_cmd
);

  localparam int SCAN_ROWS = PANEL_HEIGHT / 2;

  logic row_ok;
  logic col_ok;
  logic keep;

  // an odd last row is never scanned, so it is not stored
  assign in_ready = q_space && !init_busy;
  assign row_ok   = {1'b0, pixel_row} < 9'(2 * SCAN_ROWS);
  assign col_ok   = {1'b0, pixel_col} < 9'(PANEL_WIDTH);

  always_comb begin
    push_cmd.bottom = pixel_row >= 8'(SCAN_ROWS);
    push_cmd.row    = push_cmd.bottom ? pixel_row - 8'(SCAN_ROWS) : pixel_row;
    push_cmd.col    = pixel_col;
    push_cmd.rgb    = {blue_in, green_in, red_in};
    push_cmd.kind   = rmsd_pkg::CMD_SCAN;
    keep            = 1'b0;
    unique case (mode)
      rmsd_pkg::MODE_WRITE: begin
        push_cmd.kind = rmsd_pkg::CMD_WRITE;
        keep          = row_ok && col_ok;
      end
      rmsd_pkg::MODE_SCAN: begin
        push_cmd.kind = rmsd_pkg::CMD_SCAN;
        keep          = 1'b1;
      end
      rmsd_pkg::MODE_CLEAR: begin
        push_cmd.kind = rmsd_pkg::CMD_CLEAR;
        keep          = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = in_valid && in_ready && keep;

endmodule

// ----- hdl/rmsd_queue.sv -----
// rmsd_queue: short FIFO of command words between front and back.
// Depends on rmsd_pkg.
`timescale 1ns / 1ps

module rmsd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rmsd_pkg::cmd_t push_cmd,
  output logic           space,
  input  logic           pop,
  output logic           q_valid,
  output rmsd_pkg::cmd_t q_cmd
);

  localparam int DEPTH = rmsd_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  rmsd_pkg::cmd_t slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign space   = count_r != CW'(DEPTH);
  assign q_valid = count_r != '0;
  assign q_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue popped while empty");
`endif

endmodule

// ----- hdl/rmsd_back.sv -----
// rmsd_back: frame store (upper and lower half memories), clear sweep, scan counters
// and the registered result stage. Depends on rmsd_pkg.
`timescale 1ns / 1ps

module rmsd_back #(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  rmsd_pkg::cmd_t       q_cmd,
  output logic                 q_pop,
  output logic                 init_busy,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [2:0]           out_top,
  output logic [2:0]           out_bot,
  output rmsd_pkg::scan_meta_t out_meta
);

  localparam int SCAN_ROWS  = PANEL_HEIGHT / 2;
  localparam int HALF_DEPTH = SCAN_ROWS * PANEL_WIDTH;
  localparam int AW         = $clog2(HALF_DEPTH);
  localparam int COL_W      = $clog2(PANEL_WIDTH);
  localparam int SROW_W     = $clog2(SCAN_ROWS);

  rmsd_pkg::back_state_t state_r, state_nxt;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic [SROW_W-1:0]     scan_row_r, scan_row_nxt;
  logic [COL_W-1:0]      scan_col_r, scan_col_nxt;
  logic [AW-1:0]         scan_addr_r, scan_addr_nxt;
  logic                  p_valid_r, p_valid_nxt;
  rmsd_pkg::scan_meta_t  p_meta_r, p_meta_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            out_top_r, out_bot_r;
  rmsd_pkg::scan_meta_t  out_meta_r;
  logic [2:0]            rd_top_r, rd_bot_r;

  logic [2:0]            mem_top [HALF_DEPTH];
  logic [2:0]            mem_bot [HALF_DEPTH];

  logic [AW-1:0]         cmd_addr;
  logic [AW-1:0]         waddr;
  logic [2:0]            wdata;
  logic                  we_top, we_bot;
  logic                  rd_en;
  logic                  load_out;
  logic                  last_col, last_row;

  assign cmd_addr  = AW'(16'(q_cmd.row) * 16'(PANEL_WIDTH) + 16'(q_cmd.col));
  assign load_out  = p_valid_r && (!out_valid_r || out_ready);
  assign init_busy = state_r == rmsd_pkg::BK_INIT;

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    q_pop        = 1'b0;
    we_top       = 1'b0;
    we_bot       = 1'b0;
    waddr        = cmd_addr;
    wdata        = q_cmd.rgb;
    rd_en        = 1'b0;
    unique case (state_r)
      rmsd_pkg::BK_INIT, rmsd_pkg::BK_CLEAR: begin
        we_top = 1'b1;
        we_bot = 1'b1;
        waddr  = clr_addr_r;
        wdata  = '0;
        if (clr_addr_r == AW'(HALF_DEPTH - 1)) begin
          state_nxt    = rmsd_pkg::BK_RUN;
          clr_addr_nxt = '0;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      rmsd_pkg::BK_RUN: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            rmsd_pkg::CMD_WRITE: begin
              q_pop  = 1'b1;
              we_top = !q_cmd.bottom;
              we_bot = q_cmd.bottom;
            end
            rmsd_pkg::CMD_SCAN: begin
              if (!p_valid_r || load_out) begin
                q_pop = 1'b1;
                rd_en = 1'b1;
              end
            end
            rmsd_pkg::CMD_CLEAR: begin
              q_pop     = 1'b1;
              state_nxt = rmsd_pkg::BK_CLEAR;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      default: state_nxt = rmsd_pkg::BK_INIT;
    endcase
  end

  // scan position and per-column flags
  always_comb begin
    last_col      = scan_col_r == COL_W'(PANEL_WIDTH - 1);
    last_row      = scan_row_r == SROW_W'(SCAN_ROWS - 1);
    scan_row_nxt  = scan_row_r;
    scan_col_nxt  = scan_col_r;
    scan_addr_nxt = scan_addr_r;
    if (rd_en) begin
      if (last_col) begin
        scan_col_nxt = '0;
        scan_row_nxt = last_row ? '0 : scan_row_r + 1'b1;
      end else begin
        scan_col_nxt = scan_col_r + 1'b1;
      end
      scan_addr_nxt = (last_col && last_row) ? '0 : scan_addr_r + 1'b1;
    end
    p_meta_nxt.row_address = 4'(scan_row_r);
    p_meta_nxt.latch       = last_col;
    p_meta_nxt.blank       = !last_col;
    p_meta_nxt.frame_last  = last_col && last_row;
    p_valid_nxt            = rd_en || (p_valid_r && !load_out);
    out_valid_nxt          = load_out || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmsd_pkg::BK_INIT;
      clr_addr_r  <= '0;
      scan_row_r  <= '0;
      scan_col_r  <= '0;
      scan_addr_r <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      scan_row_r  <= scan_row_nxt;
      scan_col_r  <= scan_col_nxt;
      scan_addr_r <= scan_addr_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      p_meta_r <= p_meta_nxt;
    end
    if (load_out) begin
      out_top_r  <= rd_top_r;
      out_bot_r  <= rd_bot_r;
      out_meta_r <= p_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we_top) begin
      mem_top[waddr] <= wdata;
    end
    if (we_bot) begin
      mem_bot[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_top_r <= mem_top[scan_addr_r];
      rd_bot_r <= mem_bot[scan_addr_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_top   = out_top_r;
  assign out_bot   = out_bot_r;
  assign out_meta  = out_meta_r;

`ifndef SYNTHESIS
  a_init_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != rmsd_pkg::BK_RUN |-> !q_pop)
    else $error("queue popped during clear sweep");

  a_addr_track: assert property (@(posedge clk) disable iff (!rst_n)
    scan_addr_r == AW'(16'(scan_row_r) * 16'(PANEL_WIDTH) + 16'(scan_col_r)))
    else $error("scan address out of step with row/column");

  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> p_valid_r)
    else $error("issued read lost before result stage");
`endif

endmodule

// ----- hdl/rgb_matrix_scan_driver.sv -----
// Top level of the RGB matrix scan driver: front classifier, command queue, frame-store back end.
// Depends on rmsd_pkg, rmsd_if, rmsd_front, rmsd_queue, rmsd_back.
//
//   channel  dir  word
//   in_bus   in   mode, pixel_row, pixel_col, red_in, green_in, blue_in
//   out_bus  out  top/bottom rgb, row_address, latch, blank, frame_last
//
// A scan tick's pixels pass the read register, then the result register, before out_bus.valid rises.
// A clear writes zero to every address of both half memories, one address a cycle.
// After reset the same sweep runs with in_bus.ready low.
// A stalled output holds the result stage; the 2-word queue absorbs input meanwhile.
`timescale 1ns / 1ps

module rgb_matrix_scan_driver #(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 32
) (
  input logic         clk,
  input logic         rst_n,
  rmsd_in_if.sink     in_bus,
  rmsd_out_if.source  out_bus
);

  logic                 q_space;
  logic                 init_busy;
  logic                 push;
  rmsd_pkg::cmd_t       push_cmd;
  logic                 q_pop;
  logic                 q_valid;
  rmsd_pkg::cmd_t       q_cmd;
  logic [2:0]           out_top;
  logic [2:0]           out_bot;
  rmsd_pkg::scan_meta_t out_meta;

  rmsd_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .mode      (in_bus.mode),
    .pixel_row (in_bus.pixel_row),
    .pixel_col (in_bus.pixel_col),
    .red_in    (in_bus.red_in),
    .green_in  (in_bus.green_in),
    .blue_in   (in_bus.blue_in),
    .q_space   (q_space),
    .init_busy (init_busy),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  rmsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .space    (q_space),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  rmsd_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_ready (out_bus.ready),
    .out_valid (out_bus.valid),
    .out_top   (out_top),
    .out_bot   (out_bot),
    .out_meta  (out_meta)
  );

  assign out_bus.top_red      = out_top[0];
  assign out_bus.top_green    = out_top[1];
  assign out_bus.top_blue     = out_top[2];
  assign out_bus.bottom_red   = out_bot[0];
  assign out_bus.bottom_green = out_bot[1];
  assign out_bus.bottom_blue  = out_bot[2];
  assign out_bus.row_address  = out_meta.row_address;
  assign out_bus.latch        = out_meta.latch;
  assign out_bus.blank        = out_meta.blank;
  assign out_bus.frame_last   = out_meta.frame_last;

endmodule
